[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/dnsp_pkg.sv]
// Types and constants of the DNS response A-record parser.
package dnsp_pkg;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic REG_EXPECTED_ID = 1'b0;

    localparam logic [3:0]  HEADER_LAST    = 4'd11;
    localparam logic [3:0]  POS_ID_LO      = 4'd1;
    localparam logic [3:0]  POS_FLAGS_LO   = 4'd3;
    localparam logic [3:0]  POS_QDCOUNT_LO = 4'd5;
    localparam logic [3:0]  POS_ANCOUNT_LO = 4'd7;
    localparam logic [7:0]  POINTER_MARK   = 8'hC0;
    localparam logic [15:0] QUESTION_TAIL  = 16'd4;
    localparam logic [15:0] RECORD_FIXED   = 16'd10;
    localparam logic [15:0] TYPE_A         = 16'd1;
    localparam logic [15:0] ADDR_BYTES     = 16'd4;
    localparam int unsigned QR_BIT         = 15;

    typedef enum logic [2:0] {
        ST_FOUND    = 3'd0,
        ST_NO_A     = 3'd1,
        ST_SHORT    = 3'd2,
        ST_ID       = 3'd3,
        ST_NOT_RESP = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        PH_HEADER    = 4'd0,
        PH_QLABEL    = 4'd1,
        PH_QSKIP     = 4'd2,
        PH_QTAIL     = 4'd3,
        PH_ALABEL    = 4'd4,
        PH_ASKIPNAME = 4'd5,
        PH_AFIXED    = 4'd6,
        PH_ADATA     = 4'd7,
        PH_ASKIP     = 4'd8,
        PH_DONE      = 4'd9
    } phase_t;

    typedef struct packed {
        logic       last_byte;
        logic [7:0] byte_value;
    } beat_t;

    typedef struct packed {
        logic [31:0] address;
        status_t     status;
    } result_t;

endpackage

[rtl/dnsp_cfg.sv]
// APB register block holding the expected transaction id.
module dnsp_cfg
    import dnsp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [15:0]           expected_id
);

    logic [15:0] id_reg;
    logic [15:0] id_next;
    logic        wr_en;
    logic        reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1] == REG_EXPECTED_ID);
    assign wr_en   = psel && penable && pwrite && pready && reg_hit;
    assign id_next = wr_en ? pwdata[15:0] : id_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_reg <= 16'd0;
        end else begin
            id_reg <= id_next;
        end
    end

    // paddr[1:0] are byte offsets within the word
    assign prdata      = reg_hit ? {16'd0, id_reg} : '0;
    assign expected_id = id_reg;

endmodule

[rtl/dnsp_parser.sv]
// Per-byte DNS response walker: header check, name skipping, A-record capture.
module dnsp_parser
    import dnsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        beat_take,
    input  beat_t       beat,
    input  logic [15:0] expected_id,
    output result_t     result
);

    phase_t      phase_reg,   phase_next;
    status_t     verdict_reg, verdict_next;
    logic [3:0]  pos_reg,     pos_next;
    logic [15:0] hdr_reg,     hdr_next;
    logic [15:0] q_left_reg,  q_left_next;
    logic [15:0] a_left_reg,  a_left_next;
    logic [15:0] skip_reg,    skip_next;
    logic [15:0] rtype_reg,   rtype_next;
    logic [15:0] rlen_reg,    rlen_next;
    logic [31:0] addr_reg,    addr_next;

    logic [7:0]  b;
    logic [15:0] hdr_shift;
    logic [15:0] skip_dec;
    logic [15:0] q_dec;
    logic [15:0] a_dec;
    status_t     st;

    assign b         = beat.byte_value;
    assign hdr_shift = {hdr_reg[7:0], b};
    assign skip_dec  = skip_reg - 16'd1;
    assign q_dec     = q_left_reg - 16'd1;
    assign a_dec     = a_left_reg - 16'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn || (beat_take && beat.last_byte)) begin
            phase_reg   <= PH_HEADER;
            verdict_reg <= ST_NO_A;
            pos_reg     <= '0;
            hdr_reg     <= '0;
            q_left_reg  <= '0;
            a_left_reg  <= '0;
            skip_reg    <= '0;
            rtype_reg   <= '0;
            rlen_reg    <= '0;
            addr_reg    <= '0;
        end else if (beat_take) begin
            phase_reg   <= phase_next;
            verdict_reg <= verdict_next;
            pos_reg     <= pos_next;
            hdr_reg     <= hdr_next;
            q_left_reg  <= q_left_next;
            a_left_reg  <= a_left_next;
            skip_reg    <= skip_next;
            rtype_reg   <= rtype_next;
            rlen_reg    <= rlen_next;
            addr_reg    <= addr_next;
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        verdict_next = verdict_reg;
        pos_next     = pos_reg;
        hdr_next     = hdr_reg;
        q_left_next  = q_left_reg;
        a_left_next  = a_left_reg;
        skip_next    = skip_reg;
        rtype_next   = rtype_reg;
        rlen_next    = rlen_reg;
        addr_next    = addr_reg;
        unique case (phase_reg)
            PH_HEADER: begin
                hdr_next = hdr_shift;
                pos_next = pos_reg + 4'd1;
                if (pos_reg == POS_ID_LO && hdr_shift != expected_id) begin
                    verdict_next = ST_ID;
                end else if (pos_reg == POS_FLAGS_LO && verdict_reg == ST_NO_A
                             && !hdr_shift[QR_BIT]) begin
                    verdict_next = ST_NOT_RESP;
                end else if (pos_reg == POS_QDCOUNT_LO) begin
                    q_left_next = hdr_shift;
                end else if (pos_reg == POS_ANCOUNT_LO) begin
                    a_left_next = hdr_shift;
                end else if (pos_reg == HEADER_LAST) begin
                    if (verdict_reg != ST_NO_A) begin
                        phase_next = PH_DONE;
                    end else if (q_left_reg != 16'd0) begin
                        phase_next = PH_QLABEL;
                    end else begin
                        phase_next = (a_left_reg == 16'd0) ? PH_DONE : PH_ALABEL;
                    end
                end
            end
            PH_QLABEL, PH_ALABEL: begin
                if (b == 8'd0) begin
                    phase_next = (phase_reg == PH_QLABEL) ? PH_QTAIL : PH_AFIXED;
                    skip_next  = (phase_reg == PH_QLABEL) ? QUESTION_TAIL : RECORD_FIXED;
                end else if ((b & POINTER_MARK) == POINTER_MARK) begin
                    // pointer: one more byte, then the fixed part
                    phase_next = (phase_reg == PH_QLABEL) ? PH_QTAIL : PH_AFIXED;
                    skip_next  = (phase_reg == PH_QLABEL) ? QUESTION_TAIL + 16'd1
                                                          : RECORD_FIXED + 16'd1;
                end else begin
                    phase_next = (phase_reg == PH_QLABEL) ? PH_QSKIP : PH_ASKIPNAME;
                    skip_next  = {8'd0, b};
                end
            end
            PH_QSKIP, PH_ASKIPNAME: begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0) begin
                    phase_next = (phase_reg == PH_QSKIP) ? PH_QLABEL : PH_ALABEL;
                end
            end
            PH_QTAIL: begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0) begin
                    q_left_next = q_dec;
                    if (q_dec != 16'd0) begin
                        phase_next = PH_QLABEL;
                    end else begin
                        phase_next = (a_left_reg == 16'd0) ? PH_DONE : PH_ALABEL;
                    end
                end
            end
            PH_AFIXED: begin
                // type is fixed bytes 0..1, data length bytes 8..9
                if (skip_reg == RECORD_FIXED || skip_reg == RECORD_FIXED - 16'd1) begin
                    rtype_next = {rtype_reg[7:0], b};
                end else if (skip_reg == 16'd2 || skip_reg == 16'd1) begin
                    rlen_next = {rlen_reg[7:0], b};
                end
                skip_next = skip_dec;
                if (skip_dec == 16'd0) begin
                    if (rtype_next == TYPE_A && rlen_next == ADDR_BYTES) begin
                        phase_next = PH_ADATA;
                        skip_next  = ADDR_BYTES;
                        addr_next  = '0;
                    end else if (rlen_next == 16'd0) begin
                        a_left_next = a_dec;
                        phase_next  = (a_dec == 16'd0) ? PH_DONE : PH_ALABEL;
                    end else begin
                        phase_next = PH_ASKIP;
                        skip_next  = rlen_next;
                    end
                end
            end
            PH_ADATA: begin
                addr_next = {addr_reg[23:0], b};
                skip_next = skip_dec;
                if (skip_dec == 16'd0) begin
                    verdict_next = ST_FOUND;
                    phase_next   = PH_DONE;
                end
            end
            PH_ASKIP: begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0) begin
                    a_left_next = a_dec;
                    phase_next  = (a_dec == 16'd0) ? PH_DONE : PH_ALABEL;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign st             = (phase_next == PH_HEADER) ? ST_SHORT : verdict_next;
    assign result.status  = st;
    assign result.address = (st == ST_FOUND) ? addr_next : 32'd0;

endmodule

[rtl/dns_response_a_record_parser_core.sv]
// Top level of the DNS response A-record parser.
// Input stream: one payload byte per beat on s_tdata, s_tlast on the final byte.
// Output stream: one result beat per packet, sent for the beat that carried s_tlast;
//   m_tdata holds the status and the IPv4 address (zero unless status is found).
// Bytes pass an input register, are parsed by combinational logic, and the result
// is held in an output register that drives m_tvalid. One byte is taken per cycle
// while no last byte waits on a full output; the per-packet parse state updates
// once per byte, which sets that rate. expected_id is written over APB at address 0;
// the user must write it only while no packet is in flight; the block does not check.
// A stalled m_tready holds the result; bytes that are not last keep flowing, and
// the last byte of the next packet waits in the input register, so s_tready drops.
// Synchronous reset clears the parse state, both valid flags and expected_id.
`include "assert_macros.svh"
module dns_response_a_record_parser_core
    import dnsp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] byte_value
    input  logic                  s_tlast,   // last_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // [2:0] status, [34:3] address, zero fill
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic        in_vld_reg, in_vld_next;
    beat_t       in_reg;
    logic        out_vld_reg, out_vld_next;
    result_t     out_reg;
    result_t     parse_res;
    logic        consume;
    logic [15:0] expected_id;

    dnsp_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .expected_id (expected_id)
    );

    dnsp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_take   (consume),
        .beat        (in_reg),
        .expected_id (expected_id),
        .result      (parse_res)
    );

    // a last byte needs a free output slot
    assign consume  = in_vld_reg && (!in_reg.last_byte || !out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || consume;

    assign in_vld_next  = (s_tvalid && s_tready) ? 1'b1 : (consume ? 1'b0 : in_vld_reg);
    assign out_vld_next = (consume && in_reg.last_byte) ? 1'b1
                        : (m_tready ? 1'b0 : out_vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.byte_value <= s_tdata;
            in_reg.last_byte  <= s_tlast;
        end
        if (consume && in_reg.last_byte) begin
            out_reg <= parse_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'd0, out_reg.address, out_reg.status};

    `ASSERT_RST(a_last_gives_result, aclk, aresetn, (consume && in_reg.last_byte) |=> m_tvalid, "last byte gave no result")
    `ASSERT_RST(a_addr_zero, aclk, aresetn, (m_tvalid && out_reg.status != ST_FOUND) |-> (out_reg.address == 32'd0), "address set without a find")
    `ASSERT_RST(a_stall_holds_byte, aclk, aresetn, !s_tready |-> (in_vld_reg && in_reg.last_byte && out_vld_reg), "input stalled without cause")
    `ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

[tb/dns_parse_checker.sv]
// Checker for the DNS A-record parser: tracks expected_id, predicts each status beat, compares.
`timescale 1ns / 100ps
module dns_parse_checker
    import dnsp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [39:0]           m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  stream_done,
    output int                    outstanding,
    output int                    fail_count
);

    localparam logic [APB_ADDR_W-1:0] ID_ADDR = {REG_EXPECTED_ID, 2'b00};

    logic [15:0] query_id;
    logic [15:0] pos;
    phase_t      phase;
    logic [15:0] hdr_word;
    logic [15:0] q_left;
    logic [15:0] a_left;
    logic [15:0] skip_cnt;
    logic [15:0] rec_type;
    logic [15:0] rec_len;
    logic [31:0] addr_acc;
    status_t     verdict;

    result_t status_due[$];
    int      errors = 0;
    logic    leftover_done = 1'b0;

    task automatic clear_packet();
        pos      = '0;
        phase    = PH_HEADER;
        hdr_word = '0;
        q_left   = '0;
        a_left   = '0;
        skip_cnt = '0;
        rec_type = '0;
        rec_len  = '0;
        addr_acc = '0;
        verdict  = ST_NO_A;
    endtask

    task automatic enter_answers();
        if (a_left == 0) begin
            phase = PH_DONE;
        end else begin
            phase = PH_ALABEL;
        end
    endtask

    task automatic next_answer();
        a_left = a_left - 16'd1;
        enter_answers();
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic [15:0] idx;
        logic        in_q;
        in_q = (phase == PH_QLABEL);
        case (phase)
            PH_HEADER: begin
                hdr_word = {hdr_word[7:0], b};
                if (pos == POS_ID_LO && hdr_word != query_id) begin
                    verdict = ST_ID;
                end else if (pos == POS_FLAGS_LO && verdict == ST_NO_A && !hdr_word[QR_BIT]) begin
                    verdict = ST_NOT_RESP;
                end else if (pos == POS_QDCOUNT_LO) begin
                    q_left = hdr_word;
                end else if (pos == POS_ANCOUNT_LO) begin
                    a_left = hdr_word;
                end else if (pos == HEADER_LAST) begin
                    if (verdict != ST_NO_A) begin
                        phase = PH_DONE;
                    end else if (q_left != 0) begin
                        phase = PH_QLABEL;
                    end else begin
                        enter_answers();
                    end
                end
                if (pos != 16'hFFFF) pos = pos + 16'd1;
            end
            PH_QLABEL, PH_ALABEL: begin
                if (b == 8'd0) begin
                    phase    = in_q ? PH_QTAIL : PH_AFIXED;
                    skip_cnt = in_q ? QUESTION_TAIL : RECORD_FIXED;
                end else if ((b & POINTER_MARK) == POINTER_MARK) begin
                    // one more pointer byte, then the fixed part
                    phase    = in_q ? PH_QTAIL : PH_AFIXED;
                    skip_cnt = in_q ? QUESTION_TAIL + 16'd1 : RECORD_FIXED + 16'd1;
                end else begin
                    phase    = in_q ? PH_QSKIP : PH_ASKIPNAME;
                    skip_cnt = {8'd0, b};
                end
            end
            PH_QSKIP, PH_ASKIPNAME: begin
                skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 0) begin
                    phase = (phase == PH_QSKIP) ? PH_QLABEL : PH_ALABEL;
                end
            end
            PH_QTAIL: begin
                skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 0) begin
                    q_left = q_left - 16'd1;
                    if (q_left != 0) begin
                        phase = PH_QLABEL;
                    end else begin
                        enter_answers();
                    end
                end
            end
            PH_AFIXED: begin
                idx = RECORD_FIXED - skip_cnt;
                if (idx == 16'd0 || idx == 16'd1) begin
                    rec_type = {rec_type[7:0], b};
                end else if (idx == 16'd8 || idx == 16'd9) begin
                    rec_len = {rec_len[7:0], b};
                end
                skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 0) begin
                    if (rec_type == TYPE_A && rec_len == ADDR_BYTES) begin
                        phase    = PH_ADATA;
                        skip_cnt = ADDR_BYTES;
                        addr_acc = '0;
                    end else if (rec_len == 0) begin
                        next_answer();
                    end else begin
                        phase    = PH_ASKIP;
                        skip_cnt = rec_len;
                    end
                end
            end
            PH_ADATA: begin
                addr_acc = {addr_acc[23:0], b};
                skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 0) begin
                    verdict = ST_FOUND;
                    phase   = PH_DONE;
                end
            end
            PH_ASKIP: begin
                skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 0) next_answer();
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            query_id = '0;
            clear_packet();
            status_due.delete();
        end else begin
            if (psel && penable && pready && paddr == ID_ADDR) begin
                if (pwrite) begin
                    query_id = pwdata[15:0];
                end else if (prdata[15:0] != query_id) begin
                    $error("expected_id readback: expected %0h, got %0h", query_id, prdata[15:0]);
                    errors++;
                end
            end
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata);
                if (s_tlast) begin
                    if (phase == PH_HEADER) begin
                        want.status = ST_SHORT;
                    end else begin
                        want.status = verdict;
                    end
                    want.address = (want.status == ST_FOUND) ? addr_acc : 32'd0;
                    status_due.push_back(want);
                    clear_packet();
                end
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(result_t)-1:0];
                if (status_due.size() == 0) begin
                    $error("status beat with nothing expected: status %0d address %08h",
                           got.status, got.address);
                    errors++;
                end else begin
                    want = status_due.pop_front();
                    if (got.status != want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.address != want.address) begin
                        $error("address: expected %08h, got %08h", want.address, got.address);
                        errors++;
                    end
                end
            end
            if (stream_done && !leftover_done) begin
                leftover_done = 1'b1;
                if (status_due.size() != 0) begin
                    $error("%0d status beats never arrived", status_due.size());
                    errors += status_due.size();
                end
            end
        end
        outstanding <= status_due.size();
        fail_count  <= errors;
    end

endmodule

[tb/tb_top.sv]
// Testbench top for the DNS A-record parser: clock, reset, APB setup, byte stimulus, verdict.
`timescale 1ns / 100ps
module tb_top;
    import dnsp_pkg::*;

    localparam logic [APB_ADDR_W-1:0] ID_ADDR     = {REG_EXPECTED_ID, 2'b00};
    localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR = 3'd4;
    localparam int NAME_ROOT    = 0;
    localparam int NAME_POINTER = 1;
    localparam int NAME_LABELS  = 2;
    localparam int NAME_LONG    = 3;
    localparam logic [15:0] TYPE_NS    = 16'd2;
    localparam logic [15:0] TYPE_CNAME = 16'd5;
    localparam logic [15:0] TYPE_AAAA  = 16'd28;
    localparam logic [15:0] RESP_FLAGS = 16'h8180;
    localparam int STUCK_LIMIT = 1000;
    localparam int PHASE_BYTES = 180;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;   // [7:0] byte_value
    logic                  s_tlast  = 1'b0; // last_byte
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [39:0]           m_tdata;         // [2:0] status, [34:3] address, zero fill
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  stream_done = 1'b0;
    int                    outstanding;
    int                    fail_count;

    logic        idle_en = 1'b1;
    int          ready_hold = 0;
    int          stuck_cycles = 0;
    logic [7:0]  payload[$];
    logic [15:0] cur_id = '0;
    int          bytes_sent = 0;
    int          base_bytes = 0;
    int          packets = 0;
    int          id_settings = 1;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    dns_response_a_record_parser_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dns_parse_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .stream_done(stream_done),
        .outstanding(outstanding),
        .fail_count (fail_count)
    );

    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            m_tready   <= (ready_hold == 1);
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
            ready_hold <= $urandom_range(1, 5);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic put16(input logic [15:0] v);
        payload.push_back(v[15:8]);
        payload.push_back(v[7:0]);
    endtask

    task automatic put_header(input logic [15:0] id, input logic [15:0] flags,
                              input logic [15:0] qd, input logic [15:0] an);
        put16(id);
        put16(flags);
        put16(qd);
        put16(an);
        put16(16'($urandom));
        put16(16'($urandom));
    endtask

    task automatic put_name(input int kind);
        int n;
        int len;
        case (kind)
            NAME_ROOT: payload.push_back(8'd0);
            NAME_POINTER: begin
                payload.push_back(8'($urandom_range(8'hC0, 8'hFF)));
                payload.push_back(8'($urandom));
            end
            NAME_LONG: begin
                len = $urandom_range(8'h40, 8'hBF);
                payload.push_back(8'(len));
                repeat (len) payload.push_back(8'($urandom));
                payload.push_back(8'd0);
            end
            default: begin
                n = $urandom_range(1, 3);
                repeat (n) begin
                    len = $urandom_range(1, 6);
                    payload.push_back(8'(len));
                    repeat (len) payload.push_back(8'($urandom));
                end
                payload.push_back(8'd0);
            end
        endcase
    endtask

    task automatic put_question(input int kind);
        put_name(kind);
        put16(16'($urandom));
        put16(16'($urandom));
    endtask

    task automatic put_record(input int kind, input logic [15:0] rtype, input logic [15:0] rlen,
                              input int ndata, input logic [31:0] data4);
        put_name(kind);
        put16(rtype);
        put16(16'($urandom));
        put16(16'($urandom));
        put16(16'($urandom));
        put16(rlen);
        for (int i = 0; i < ndata; i++) begin
            payload.push_back((i < 4) ? data4[31 - 8 * i -: 8] : 8'($urandom));
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic lst);
        if (idle_en && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_pkt(input int keep);
        for (int i = 0; i < keep; i++) begin
            send_byte(payload[i], i == keep - 1);
        end
        payload.delete();
        packets++;
    endtask

    task automatic send_whole();
        send_pkt(payload.size());
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write_read(input logic [APB_ADDR_W-1:0] addr, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic int pick_name();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return NAME_ROOT;
        if (r < 60) return NAME_POINTER;
        if (r < 97) return NAME_LABELS;
        return NAME_LONG;
    endfunction

    task automatic random_packet();
        int          r;
        int          qd;
        int          an;
        int          keep;
        logic [15:0] hq;
        logic [15:0] ha;
        logic [15:0] id;
        logic [15:0] flags;
        logic [15:0] rtype;
        logic [15:0] rlen;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            repeat ($urandom_range(1, 40)) payload.push_back(8'($urandom));
            send_whole();
        end else begin
            id    = ($urandom_range(0, 9) == 0) ? 16'($urandom) : cur_id;
            flags = 16'($urandom);
            if ($urandom_range(0, 9) != 0) flags[QR_BIT] = 1'b1;
            qd = $urandom_range(0, 2);
            an = $urandom_range(0, 3);
            hq = 16'(qd);
            ha = 16'(an);
            if ($urandom_range(0, 19) == 0) hq = 16'($urandom);
            if ($urandom_range(0, 19) == 0) ha = 16'($urandom);
            put_header(id, flags, hq, ha);
            repeat (qd) put_question(pick_name());
            repeat (an) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: put_record(pick_name(), TYPE_A, ADDR_BYTES, 4, $urandom);
                    6: begin
                        rlen = 16'($urandom_range(0, 6));
                        put_record(pick_name(), TYPE_A, rlen, int'(rlen), $urandom);
                    end
                    7: begin
                        rtype = 16'($urandom);
                        rlen  = 16'($urandom);
                        put_record(pick_name(), rtype, rlen, 6, $urandom);
                    end
                    default: begin
                        case ($urandom_range(0, 2))
                            0: rtype = TYPE_NS;
                            1: rtype = TYPE_CNAME;
                            default: rtype = TYPE_AAAA;
                        endcase
                        rlen = 16'($urandom_range(0, 6));
                        put_record(pick_name(), rtype, rlen, int'(rlen), $urandom);
                    end
                endcase
            end
            repeat ($urandom_range(0, 4)) payload.push_back(8'($urandom));
            keep = (r >= 85) ? $urandom_range(1, payload.size()) : payload.size();
            send_pkt(keep);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed cases under the reset id of zero
        put_header(16'h0000, RESP_FLAGS, 16'd1, 16'd1);
        send_pkt(1);
        put_header(16'hFFFF, 16'h0000, 16'd0, 16'd0);
        send_pkt(11);
        put_header(16'hBEEF, RESP_FLAGS, 16'd0, 16'd1);
        put_record(NAME_POINTER, TYPE_A, ADDR_BYTES, 4, 32'hC0A80001);
        send_whole();
        put_header(16'h0100, 16'h0000, 16'd0, 16'd1);
        put_record(NAME_ROOT, TYPE_A, ADDR_BYTES, 4, 32'h01010101);
        send_whole();
        put_header(16'h0000, 16'h7FFF, 16'd0, 16'd1);
        put_record(NAME_ROOT, TYPE_A, ADDR_BYTES, 4, 32'h02020202);
        send_whole();
        put_header(16'h0000, 16'h8000, 16'd0, 16'd0);
        send_whole();
        put_header(16'h0000, RESP_FLAGS, 16'd1, 16'd1);
        put_question(NAME_LABELS);
        put_record(NAME_POINTER, TYPE_A, ADDR_BYTES, 4, 32'h0A000001);
        send_whole();
        put_header(16'h0000, 16'hFFFF, 16'd2, 16'd3);
        put_question(NAME_POINTER);
        put_question(NAME_LABELS);
        put_record(NAME_LABELS, TYPE_CNAME, 16'd3, 3, 32'h0);
        put_record(NAME_POINTER, TYPE_AAAA, 16'd0, 0, 32'h0);
        put_record(NAME_ROOT, TYPE_A, ADDR_BYTES, 4, 32'hFFFFFFFF);
        repeat (5) payload.push_back(8'($urandom));
        send_whole();
        put_header(16'h0000, RESP_FLAGS, 16'd0, 16'd3);
        put_record(NAME_ROOT, TYPE_A, 16'd5, 5, 32'h11111111);
        put_record(NAME_POINTER, TYPE_A, 16'd3, 3, 32'h22222222);
        put_record(NAME_ROOT, TYPE_A, ADDR_BYTES, 4, 32'h00000000);
        send_whole();
        put_header(16'h0000, RESP_FLAGS, 16'd0, 16'd1);
        put_record(NAME_ROOT, TYPE_A, 16'd6, 6, 32'h33333333);
        send_whole();
        put_header(16'h0000, RESP_FLAGS, 16'd0, 16'd1);
        put_record(NAME_ROOT, TYPE_A, ADDR_BYTES, 4, 32'h01020304);
        send_pkt(payload.size() - 1);
        put_header(16'h0000, RESP_FLAGS, 16'd1, 16'd1);
        put_question(NAME_LABELS);
        send_pkt(14);
        put_header(16'h0000, RESP_FLAGS, 16'd0, 16'd1);
        put_record(NAME_ROOT, TYPE_A, ADDR_BYTES, 4, 32'h05060708);
        send_pkt(18);
        put_header(16'h0000, RESP_FLAGS, 16'd1, 16'd0);
        send_whole();
        put_header(16'h0000, RESP_FLAGS, 16'd1, 16'd1);
        put_question(NAME_LONG);
        put_record(NAME_LONG, TYPE_A, ADDR_BYTES, 4, 32'h7F000001);
        send_whole();
        wait_idle();
        base_bytes = bytes_sent;

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 0) begin
                cur_id = 16'hFFFF;
            end else if (ph == 1) begin
                cur_id = 16'h0000;
            end else begin
                cur_id = 16'($urandom);
            end
            apb_write_read(ID_ADDR, cur_id);
            if (ph == 2) apb_write_read(UNUSED_ADDR, 16'($urandom));
            id_settings++;
            idle_en <= (ph != 5);
            while (bytes_sent < base_bytes + (ph + 1) * PHASE_BYTES) random_packet();
            wait_idle();
        end

        stream_done <= 1'b1;
        @(posedge aclk);
        @(posedge aclk);
        $display("Sent %0d payload bytes in %0d packets under %0d expected-id settings;",
                 bytes_sent, packets, id_settings);
        $display("header rejects, short and truncated packets, pointers and record skips hit.");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/dnsp_pkg.sv
rtl/dnsp_cfg.sv
rtl/dnsp_parser.sv
rtl/dns_response_a_record_parser_core.sv
tb/dns_parse_checker.sv
tb/tb_top.sv
